// ----- sv/obbsat_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package obbsat_pkg;

    localparam int COORD_BITS     = 24;
    localparam int UNIT_FRAC_BITS = 14;
    localparam int SIZE_BITS      = COORD_BITS - 1;
    localparam int UNIT_BITS      = UNIT_FRAC_BITS + 2;

    typedef enum logic [2:0] {
        AXIS_A_UP    = 3'd0,
        AXIS_A_RIGHT = 3'd1,
        AXIS_B_UP    = 3'd2,
        AXIS_B_RIGHT = 3'd3,
        AXIS_NONE    = 3'd4
    } axis_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_centre_x;
        logic signed [COORD_BITS-1:0] a_centre_y;
        logic        [SIZE_BITS-1:0]  a_width;
        logic        [SIZE_BITS-1:0]  a_height;
        logic signed [UNIT_BITS-1:0]  a_up_x;
        logic signed [UNIT_BITS-1:0]  a_up_y;
        logic signed [COORD_BITS-1:0] b_centre_x;
        logic signed [COORD_BITS-1:0] b_centre_y;
        logic        [SIZE_BITS-1:0]  b_width;
        logic        [SIZE_BITS-1:0]  b_height;
        logic signed [UNIT_BITS-1:0]  b_up_x;
        logic signed [UNIT_BITS-1:0]  b_up_y;
    } pair_t;

    typedef struct packed {
        logic  collided;
        axis_t separating_axis;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/obb_separating_axis_test_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// separating-axis overlap test for two oriented rectangles
// input channel: a box pair beat on pair is taken at each rising edge where
//   start is high and busy is low; busy is never raised, so a pair may be
//   offered in every cycle
// output channel: result is shown for exactly one cycle with done high;
//   the receiver takes it at the edge that ends that cycle and cannot stall
// a pair taken goes through the input registers, the axis lane stages and
//   the result register before its result shows with done high
// throughput: one pair per cycle, set by the fully pipelined axis lanes
//   (four lanes, one per tested axis, each four register stages deep)
// results leave in the order the pairs came in
// reset: clears the valid bits, so no result appears until a new pair is
//   taken; pairs in flight at reset are dropped
// collided is 1 when no axis separates; separating_axis names the first
//   separating axis in the order a up, a right, b up, b right, else none

module obb_separating_axis_test_unit #(
    parameter int COORD_BITS     = obbsat_pkg::COORD_BITS,
    parameter int UNIT_FRAC_BITS = obbsat_pkg::UNIT_FRAC_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire obbsat_pkg::pair_t   pair,
    output logic                     done,
    output obbsat_pkg::result_t      result
);

    localparam int SB    = COORD_BITS - 1;
    localparam int UB    = UNIT_FRAC_BITS + 2;
    localparam int NB    = UB + 1;
    localparam int DB    = COORD_BITS + 1;
    localparam int DEPTH = 5;

    logic signed [COORD_BITS-1:0] acx, acy, bcx, bcy;
    logic signed [UB-1:0]         aux, auy, bux, buy;

    logic signed [DB-1:0] dx_reg, dy_reg;
    logic signed [UB-1:0] aux_reg, auy_reg, bux_reg, buy_reg;
    logic signed [NB-1:0] anux_reg, bnux_reg;
    logic        [SB-1:0] aw_reg, ah_reg, bw_reg, bh_reg;

    logic [3:0]           sep;
    logic [DEPTH-1:0]     valid_reg;
    logic                 done_reg;
    obbsat_pkg::result_t  result_reg, result_next;

    assign busy = 1'b0;

    assign acx = COORD_BITS'(pair.a_centre_x);
    assign acy = COORD_BITS'(pair.a_centre_y);
    assign bcx = COORD_BITS'(pair.b_centre_x);
    assign bcy = COORD_BITS'(pair.b_centre_y);
    assign aux = UB'(pair.a_up_x);
    assign auy = UB'(pair.a_up_y);
    assign bux = UB'(pair.b_up_x);
    assign buy = UB'(pair.b_up_y);

    // centre difference and right-vector negation
    always_ff @(posedge clk)
    begin
        dx_reg   <= DB'(bcx) - DB'(acx);
        dy_reg   <= DB'(bcy) - DB'(acy);
        aux_reg  <= aux;
        auy_reg  <= auy;
        bux_reg  <= bux;
        buy_reg  <= buy;
        anux_reg <= -NB'(aux);
        bnux_reg <= -NB'(bux);
        aw_reg   <= SB'(pair.a_width);
        ah_reg   <= SB'(pair.a_height);
        bw_reg   <= SB'(pair.b_width);
        bh_reg   <= SB'(pair.b_height);
    end

    obbsat_axis #(.COORD_BITS(COORD_BITS), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_a_up (
        .clk (clk),
        .dx  (dx_reg),
        .dy  (dy_reg),
        .nx  (NB'(aux_reg)),
        .ny  (NB'(auy_reg)),
        .oux (bux_reg),
        .ouy (buy_reg),
        .ow  (bw_reg),
        .oh  (bh_reg),
        .own (ah_reg),
        .sep (sep[0])
    );

    obbsat_axis #(.COORD_BITS(COORD_BITS), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_a_right (
        .clk (clk),
        .dx  (dx_reg),
        .dy  (dy_reg),
        .nx  (NB'(auy_reg)),
        .ny  (anux_reg),
        .oux (bux_reg),
        .ouy (buy_reg),
        .ow  (bw_reg),
        .oh  (bh_reg),
        .own (aw_reg),
        .sep (sep[1])
    );

    obbsat_axis #(.COORD_BITS(COORD_BITS), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_b_up (
        .clk (clk),
        .dx  (dx_reg),
        .dy  (dy_reg),
        .nx  (NB'(bux_reg)),
        .ny  (NB'(buy_reg)),
        .oux (aux_reg),
        .ouy (auy_reg),
        .ow  (aw_reg),
        .oh  (ah_reg),
        .own (bh_reg),
        .sep (sep[2])
    );

    obbsat_axis #(.COORD_BITS(COORD_BITS), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_b_right (
        .clk (clk),
        .dx  (dx_reg),
        .dy  (dy_reg),
        .nx  (NB'(buy_reg)),
        .ny  (bnux_reg),
        .oux (aux_reg),
        .ouy (auy_reg),
        .ow  (aw_reg),
        .oh  (ah_reg),
        .own (bw_reg),
        .sep (sep[3])
    );

    // first separating axis wins
    always_comb
    begin
        result_next.collided = 1'b0;
        if (sep[0])
        begin
            result_next.separating_axis = obbsat_pkg::AXIS_A_UP;
        end
        else if (sep[1])
        begin
            result_next.separating_axis = obbsat_pkg::AXIS_A_RIGHT;
        end
        else if (sep[2])
        begin
            result_next.separating_axis = obbsat_pkg::AXIS_B_UP;
        end
        else if (sep[3])
        begin
            result_next.separating_axis = obbsat_pkg::AXIS_B_RIGHT;
        end
        else
        begin
            result_next.separating_axis = obbsat_pkg::AXIS_NONE;
            result_next.collided        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], start & ~busy};
            done_reg  <= valid_reg[DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_result_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start & ~busy, DEPTH + 1))
        else $error("result beat without an accepted pair");

    a_hit_matches_axis: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.collided == (result.separating_axis == obbsat_pkg::AXIS_NONE)))
        else $error("collided flag disagrees with separating axis");

    a_lane_alignment: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(valid_reg[DEPTH-1]))
        else $error("done out of step with the valid chain");

endmodule

`default_nettype wire

// ----- sv/obbsat_axis.sv -----
`timescale 1ns / 1ps
`default_nettype none

module obbsat_axis #(
    parameter int COORD_BITS     = obbsat_pkg::COORD_BITS,
    parameter int UNIT_FRAC_BITS = obbsat_pkg::UNIT_FRAC_BITS
) (
    input  wire logic                          clk,
    input  wire logic signed [COORD_BITS:0]    dx,
    input  wire logic signed [COORD_BITS:0]    dy,
    input  wire logic signed [UNIT_FRAC_BITS+2:0] nx,
    input  wire logic signed [UNIT_FRAC_BITS+2:0] ny,
    input  wire logic signed [UNIT_FRAC_BITS+1:0] oux,
    input  wire logic signed [UNIT_FRAC_BITS+1:0] ouy,
    input  wire logic        [COORD_BITS-2:0]  ow,
    input  wire logic        [COORD_BITS-2:0]  oh,
    input  wire logic        [COORD_BITS-2:0]  own,
    output logic                               sep
);

    localparam int SB  = COORD_BITS - 1;
    localparam int UB  = UNIT_FRAC_BITS + 2;
    localparam int NB  = UB + 1;
    localparam int DB  = COORD_BITS + 1;
    localparam int DPB = DB + NB;
    localparam int PB  = UB + NB;
    localparam int EB  = SB + PB;
    localparam int W   = COORD_BITS + 2 * UNIT_FRAC_BITS + 6;

    // stage 1: products
    logic signed [DPB-1:0] pdx_reg, pdy_reg;
    logic signed [PB-1:0]  pu1_reg, pu2_reg, pr1_reg, pr2_reg;
    logic        [SB-1:0]  ow1_reg, oh1_reg, own1_reg;

    // stage 2: magnitudes
    logic signed [DPB:0]   d_sum;
    logic signed [PB:0]    pu_sum, pr_sum;
    logic        [DPB-1:0] d2_reg;
    logic        [PB-1:0]  pu_reg, pr_reg;
    logic        [SB-1:0]  ow2_reg, oh2_reg, own2_reg;

    // stage 3: extent products
    logic        [EB-1:0]  eh_reg, ew_reg;
    logic        [DPB-1:0] d3_reg;
    logic        [SB-1:0]  own3_reg;

    // stage 4: compare
    logic [W-1:0] lhs, rhs;
    logic         sep_reg;

    assign d_sum  = (DPB+1)'(pdx_reg) + (DPB+1)'(pdy_reg);
    assign pu_sum = (PB+1)'(pu1_reg) + (PB+1)'(pu2_reg);
    assign pr_sum = (PB+1)'(pr1_reg) - (PB+1)'(pr2_reg);

    assign lhs = W'(d3_reg) << (UNIT_FRAC_BITS + 1);
    assign rhs = W'(eh_reg) + W'(ew_reg) + (W'(own3_reg) << (2 * UNIT_FRAC_BITS));

    always_ff @(posedge clk)
    begin
        pdx_reg  <= DPB'(dx) * DPB'(nx);
        pdy_reg  <= DPB'(dy) * DPB'(ny);
        pu1_reg  <= PB'(oux) * PB'(nx);
        pu2_reg  <= PB'(ouy) * PB'(ny);
        pr1_reg  <= PB'(ouy) * PB'(nx);
        pr2_reg  <= PB'(oux) * PB'(ny);
        ow1_reg  <= ow;
        oh1_reg  <= oh;
        own1_reg <= own;

        d2_reg   <= d_sum[DPB] ? DPB'(-d_sum) : DPB'(d_sum);
        pu_reg   <= pu_sum[PB] ? PB'(-pu_sum) : PB'(pu_sum);
        pr_reg   <= pr_sum[PB] ? PB'(-pr_sum) : PB'(pr_sum);
        ow2_reg  <= ow1_reg;
        oh2_reg  <= oh1_reg;
        own2_reg <= own1_reg;

        eh_reg   <= EB'(oh2_reg) * EB'(pu_reg);
        ew_reg   <= EB'(ow2_reg) * EB'(pr_reg);
        d3_reg   <= d2_reg;
        own3_reg <= own2_reg;

        sep_reg  <= lhs > rhs;
    end

    assign sep = sep_reg;

endmodule

`default_nettype wire

// ----- sim/tb_obb_separating_axis_test_unit.sv -----
`timescale 1ns / 1ps

module tb_obb_separating_axis_test_unit;

    import obbsat_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    pair_t   pair;
    logic    done;
    result_t result;

    result_t pending_results[$];
    int      error_count = 0;

    obb_separating_axis_test_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .pair   (pair),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #5ms;
        $display("[obb_separating_axis_test_unit] ERROR");
        $finish;
    end

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic bit axis_separates(input longint dx, input longint dy,
                                          input longint nx, input longint ny,
                                          input longint oux, input longint ouy,
                                          input longint ow, input longint oh,
                                          input longint own);
        logic [127:0] lhs;
        logic [127:0] rhs;
        lhs = 128'(magnitude(dx * nx + dy * ny)) << (UNIT_FRAC_BITS + 1);
        rhs = 128'(oh) * 128'(magnitude(oux * nx + ouy * ny))
            + 128'(ow) * 128'(magnitude(ouy * nx - oux * ny))
            + (128'(own) << (2 * UNIT_FRAC_BITS));
        return lhs > rhs;
    endfunction

    function automatic result_t predict_overlap(input pair_t p);
        longint  acx, acy, bcx, bcy, aux, auy, bux, buy, aw, ah, bw, bh, dx, dy;
        result_t r;
        acx = longint'($signed(p.a_centre_x));
        acy = longint'($signed(p.a_centre_y));
        bcx = longint'($signed(p.b_centre_x));
        bcy = longint'($signed(p.b_centre_y));
        aux = longint'($signed(p.a_up_x));
        auy = longint'($signed(p.a_up_y));
        bux = longint'($signed(p.b_up_x));
        buy = longint'($signed(p.b_up_y));
        aw  = longint'(p.a_width);
        ah  = longint'(p.a_height);
        bw  = longint'(p.b_width);
        bh  = longint'(p.b_height);
        dx  = bcx - acx;
        dy  = bcy - acy;
        if (axis_separates(dx, dy, aux, auy, bux, buy, bw, bh, ah))
            r.separating_axis = AXIS_A_UP;
        else if (axis_separates(dx, dy, auy, -aux, bux, buy, bw, bh, aw))
            r.separating_axis = AXIS_A_RIGHT;
        else if (axis_separates(dx, dy, bux, buy, aux, auy, aw, ah, bh))
            r.separating_axis = AXIS_B_UP;
        else if (axis_separates(dx, dy, buy, -bux, aux, auy, aw, ah, bw))
            r.separating_axis = AXIS_B_RIGHT;
        else
            r.separating_axis = AXIS_NONE;
        r.collided = (r.separating_axis == AXIS_NONE);
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %b/%0d",
                         $time, result.collided, result.separating_axis);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.collided !== want.collided)
                begin
                    $display("%0t collided mismatch: expected %b, actual %b",
                             $time, want.collided, result.collided);
                    error_count++;
                end
                if (result.separating_axis !== want.separating_axis)
                begin
                    $display("%0t separating_axis mismatch: expected %0d, actual %0d",
                             $time, want.separating_axis, result.separating_axis);
                    error_count++;
                end
            end
        end
    end

    task automatic send_pair(input pair_t p);
        @(negedge clk);
        start <= 1'b1;
        pair  <= p;
        forever
        begin
            @(posedge clk);
            if (busy === 1'b0)
                break;
        end
        pending_results.push_back(predict_overlap(p));
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic pair_t box_pair(input int acx, input int acy, input int aw,
                                       input int ah, input int aux, input int auy,
                                       input int bcx, input int bcy, input int bw,
                                       input int bh, input int bux, input int buy);
        pair_t p;
        p.a_centre_x = COORD_BITS'(acx);
        p.a_centre_y = COORD_BITS'(acy);
        p.a_width    = SIZE_BITS'(aw);
        p.a_height   = SIZE_BITS'(ah);
        p.a_up_x     = UNIT_BITS'(aux);
        p.a_up_y     = UNIT_BITS'(auy);
        p.b_centre_x = COORD_BITS'(bcx);
        p.b_centre_y = COORD_BITS'(bcy);
        p.b_width    = SIZE_BITS'(bw);
        p.b_height   = SIZE_BITS'(bh);
        p.b_up_x     = UNIT_BITS'(bux);
        p.b_up_y     = UNIT_BITS'(buy);
        return p;
    endfunction

    task automatic random_unit(output int ux, output int uy);
        real rem;
        ux  = int'($urandom_range(0, 32768)) - 16384;
        rem = 16384.0 * 16384.0 - real'(ux) * real'(ux);
        uy  = int'($sqrt(rem < 0.0 ? 0.0 : rem));
        if ($urandom_range(0, 1))
            uy = -uy;
    endtask

    function automatic pair_t noise_pair();
        pair_t p;
        p.a_centre_x = COORD_BITS'($urandom);
        p.a_centre_y = COORD_BITS'($urandom);
        p.a_width    = SIZE_BITS'($urandom);
        p.a_height   = SIZE_BITS'($urandom);
        p.a_up_x     = UNIT_BITS'($urandom);
        p.a_up_y     = UNIT_BITS'($urandom);
        p.b_centre_x = COORD_BITS'($urandom);
        p.b_centre_y = COORD_BITS'($urandom);
        p.b_width    = SIZE_BITS'($urandom);
        p.b_height   = SIZE_BITS'($urandom);
        p.b_up_x     = UNIT_BITS'($urandom);
        p.b_up_y     = UNIT_BITS'($urandom);
        return p;
    endfunction

    // nearby boxes with unit vectors so every axis outcome shows up
    task automatic near_pair(output pair_t p);
        int acx, acy, aw, ah, bw, bh, aux, auy, bux, buy, reach;
        int size_max;
        size_max = ($urandom_range(0, 19) == 0) ? 8388607 : 65536;
        aw  = int'($urandom_range(0, size_max));
        ah  = int'($urandom_range(0, size_max));
        bw  = int'($urandom_range(0, size_max));
        bh  = int'($urandom_range(0, size_max));
        acx = int'($urandom_range(0, 32'hFFFFFF)) - 8388608;
        acy = int'($urandom_range(0, 32'hFFFFFF)) - 8388608;
        random_unit(aux, auy);
        random_unit(bux, buy);
        reach = (aw + ah + bw + bh) / 2 + 1;
        if (reach > 4000000)
            reach = 4000000;
        p = box_pair(acx, acy, aw, ah, aux, auy,
                     acx + int'($urandom_range(0, 2 * reach)) - reach,
                     acy + int'($urandom_range(0, 2 * reach)) - reach,
                     bw, bh, bux, buy);
    endtask

    task automatic test_touching();
        send_pair(box_pair(0, 0, 1024, 1024, 0, 16384, 1024, 0, 1024, 1024, 0, 16384));
        send_pair(box_pair(0, 0, 1024, 1024, 0, 16384, 1025, 0, 1024, 1024, 0, 16384));
        send_pair(box_pair(0, 0, 1024, 1024, 0, 16384, 0, 1024, 1024, 1024, 0, 16384));
        send_pair(box_pair(0, 0, 1024, 1024, 0, 16384, 0, -1025, 1024, 1024, 0, 16384));
    endtask

    task automatic test_each_axis();
        send_pair(box_pair(0, 0, 512, 512, 0, 16384, 0, 5000, 512, 512, 0, 16384));
        send_pair(box_pair(0, 0, 512, 512, 0, 16384, 5000, 0, 512, 512, 0, 16384));
        send_pair(box_pair(0, 0, 4096, 256, 11585, 11585, 0, 900, 512, 512, 0, 16384));
        send_pair(box_pair(0, 0, 256, 4096, 11585, 11585, 900, 0, 512, 512, 0, 16384));
        send_pair(box_pair(0, 0, 1000, 1000, 11585, -11585, 100, 100, 1000, 1000,
                           0, 16384));
    endtask

    task automatic test_field_extremes();
        send_pair(box_pair(-8388608, -8388608, 8388607, 8388607, 16384, 16384,
                           8388607, 8388607, 8388607, 8388607, -16384, -16384));
        send_pair(box_pair(8388607, 8388607, 0, 0, -16384, 16384,
                           -8388608, -8388608, 0, 0, 16384, -16384));
        send_pair(box_pair(-8388608, 8388607, 8388607, 0, 0, 16384,
                           8388607, -8388608, 0, 8388607, 16384, 0));
        send_pair(box_pair(0, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 16384));
        send_pair(box_pair(-8388608, -8388608, 8388607, 8388607, -32768, -32768,
                           8388607, 8388607, 8388607, 8388607, 32767, 32767));
        send_pair(box_pair(8388607, -8388608, 0, 8388607, 32767, -32768,
                           -8388608, 8388607, 8388607, 0, -32768, 32767));
    endtask

    task automatic test_degenerate_vectors();
        send_pair(box_pair(0, 0, 1024, 1024, 0, 0, 100000, 100000, 1024, 1024, 0, 16384));
        send_pair(box_pair(0, 0, 1024, 1024, 0, 16384, 100000, 100000, 1024, 1024, 0, 0));
        send_pair(box_pair(0, 0, 1024, 1024, 0, 0, 100000, 100000, 1024, 1024, 0, 0));
        send_pair(box_pair(0, 0, 1024, 1024, 8000, 3000, 3000, 500, 1024, 1024,
                           20000, -5000));
        send_pair(box_pair(0, 0, 1024, 1024, 32767, -32768, 2000, -2000, 1024, 1024,
                           -20000, 24000));
    endtask

    task automatic test_random_pairs(input int count, input bit no_gaps);
        pair_t p;
        int    burst;
        int    sent;
        sent = 0;
        while (sent < count)
        begin
            burst = int'($urandom_range(1, 40));
            repeat (burst)
            begin
                if ($urandom_range(0, 9) < 7)
                    near_pair(p);
                else
                    p = noise_pair();
                send_pair(p);
                sent++;
            end
            if (!no_gaps && $urandom_range(0, 3) != 0)
                idle_cycles(int'($urandom_range(1, 6)));
        end
    endtask

    task automatic test_drain_pause();
        pair_t p;
        repeat (10)
        begin
            near_pair(p);
            send_pair(p);
        end
        wait_drained();
        repeat (10)
        begin
            p = noise_pair();
            send_pair(p);
        end
    endtask

    initial
    begin
        int guard;
        rst_n = 1'b0;
        start = 1'b0;
        pair  = '0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_touching();
        test_each_axis();
        test_field_extremes();
        test_degenerate_vectors();
        test_random_pairs(800, 1'b0);
        test_drain_pause();
        test_random_pairs(250, 1'b1);
        test_random_pairs(780, 1'b0);

        @(negedge clk);
        start <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
            guard++;
            if (guard > 1000)
            begin
                $display("[obb_separating_axis_test_unit] ERROR");
                $finish;
            end
        end
        repeat (12)
            @(posedge clk);

        if (error_count == 0)
            $display("[obb_separating_axis_test_unit] OK");
        else
            $display("[obb_separating_axis_test_unit] ERROR");
        $finish;
    end

endmodule
